>>> src/ldfp_pkg.sv
// shared types and constants for the lidar data frame parser
// no dependencies
`default_nettype none

package ldfp_pkg;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;
  localparam int TEMP_W  = 17;
  localparam int POS_W   = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'd89;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET  = 17'd2048;

  // register index, taken from paddr[2]
  localparam logic REG_HEADER_MARKER = 1'b0;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_HUNT    = 4'd0;
  localparam logic [POS_W-1:0] POS_DIST_LO = 4'd2;
  localparam logic [POS_W-1:0] POS_DIST_HI = 4'd3;
  localparam logic [POS_W-1:0] POS_STR_LO  = 4'd4;
  localparam logic [POS_W-1:0] POS_STR_HI  = 4'd5;
  localparam logic [POS_W-1:0] POS_TEMP_LO = 4'd6;
  localparam logic [POS_W-1:0] POS_TEMP_HI = 4'd7;

  typedef struct packed {
    logic [FIELD_W-1:0]       distance;
    logic [FIELD_W-1:0]       signal_strength;
    logic [FIELD_W-1:0]       raw_temperature;
    logic signed [TEMP_W-1:0] temperature_eighths;
    logic                     checksum_ok;
  } result_t;

endpackage

`default_nettype wire

>>> src/ldfp_frame.sv
// frame tracking: position, running sum, field capture, result forming
// depends on ldfp_pkg
`default_nettype none

module ldfp_frame #(
  parameter int FRAME_BYTES = 9
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic [ldfp_pkg::BYTE_W-1:0] data,
  input  wire logic [ldfp_pkg::BYTE_W-1:0] marker,
  output logic                            last_byte,
  output ldfp_pkg::result_t               res
);
  import ldfp_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]   pos;
  logic [BYTE_W-1:0]  running_sum;
  logic [FIELD_W-1:0] distance_hold;
  logic [FIELD_W-1:0] strength_hold;
  logic [FIELD_W-1:0] temperature_hold;

  assign last_byte = (pos != POS_HUNT) && (pos >= LAST_POS);

  always_comb begin
    res.distance            = distance_hold;
    res.signal_strength     = strength_hold;
    res.raw_temperature     = temperature_hold;
    res.temperature_eighths = $signed({1'b0, temperature_hold} - TEMP_OFFSET);
    res.checksum_ok         = (running_sum == data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= POS_HUNT;
      running_sum      <= '0;
      distance_hold    <= '0;
      strength_hold    <= '0;
      temperature_hold <= '0;
    end else if (advance) begin
      if (pos == POS_HUNT) begin
        if (data == marker) begin
          running_sum <= data;
          pos         <= POS_W'(1);
        end
      end else if (last_byte) begin
        pos         <= POS_HUNT;
        running_sum <= '0;
      end else begin
        case (pos)
          POS_DIST_LO: distance_hold[7:0]     <= data;
          POS_DIST_HI: distance_hold[15:8]    <= data;
          POS_STR_LO:  strength_hold[7:0]     <= data;
          POS_STR_HI:  strength_hold[15:8]    <= data;
          POS_TEMP_LO: temperature_hold[7:0]  <= data;
          POS_TEMP_HI: temperature_hold[15:8] <= data;
          default: ;
        endcase
        running_sum <= running_sum + data;
        pos         <= pos + POS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lidar_data_frame_parser_core.sv
// top level: byte input register, frame logic, result register, config port
// depends on ldfp_pkg and ldfp_frame
//
// usage:
//   rx_byte enters on in_valid/in_stall, one item accepted per cycle when
//   in_valid is high and in_stall is low. bytes go to a one-entry input
//   register, then through the frame logic, which holds a byte while stalled.
//   results leave on out_valid/out_stall from a result register: one result
//   per completed frame of FRAME_BYTES bytes, none for other bytes.
//   a result is registered as its last byte passes out of the input register.
//   bytes move at one per cycle, sustained, while no frame end waits on a
//   busy result register; position and running sum are updated per byte.
//   a stalled result holds the last byte of the next frame, and the bytes
//   behind it; the bytes before it keep flowing while the result waits.
//   header_marker is written through the apb port at byte address 0 and
//   reads back there.
//   reset (rst, synchronous) empties both registers, returns to hunting and
//   sets header_marker to 89.
`default_nettype none

module lidar_data_frame_parser_core #(
  parameter int FRAME_BYTES = 9
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [ldfp_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [ldfp_pkg::DATA_W-1:0]          pwdata,
  output logic [ldfp_pkg::DATA_W-1:0]               prdata,
  output logic                                      pready,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [ldfp_pkg::BYTE_W-1:0]          rx_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [ldfp_pkg::FIELD_W-1:0]              distance,
  output logic [ldfp_pkg::FIELD_W-1:0]              signal_strength,
  output logic [ldfp_pkg::FIELD_W-1:0]              raw_temperature,
  output logic signed [ldfp_pkg::TEMP_W-1:0]        temperature_eighths,
  output logic                                      checksum_ok
);
  import ldfp_pkg::*;

  logic [BYTE_W-1:0] header_marker;
  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              last_byte;
  logic              out_free;
  logic              advance;
  result_t           res;

  assign pready   = 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && (!last_byte || out_free);
  assign in_stall = in_full && !advance;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HEADER_MARKER) begin
      prdata = {{(DATA_W-BYTE_W){1'b0}}, header_marker};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_marker <= MARKER_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEADER_MARKER) begin
      header_marker <= pwdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  ldfp_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .data     (in_byte),
    .marker   (header_marker),
    .last_byte(last_byte),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_byte) begin
      distance            <= res.distance;
      signal_strength     <= res.signal_strength;
      raw_temperature     <= res.raw_temperature;
      temperature_eighths <= res.temperature_eighths;
      checksum_ok         <= res.checksum_ok;
    end
  end

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    advance && last_byte |-> out_free)
    else $error("frame end consumed while result register occupied");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_byte))
    else $error("held input byte lost or changed");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && last_byte))
    else $error("result raised without a completed frame");

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for lidar_data_frame_parser_core: byte frames with random content
// and random idling on both sides, checked against a frame predictor held in a scoreboard
// depends on ldfp_pkg and the lidar_data_frame_parser_core rtl
module tb;
  import ldfp_pkg::*;

  localparam int FRAME_LEN = 9;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 128;

  class frame_checker;
    logic [BYTE_W-1:0] marker;
    logic [POS_W-1:0] pos;
    logic [BYTE_W-1:0] sum;
    logic [FIELD_W-1:0] dist_q;
    logic [FIELD_W-1:0] str_q;
    logic [FIELD_W-1:0] temp_q;
    result_t expected_frames[$];
    int errors;

    function new();
      marker = MARKER_RESET;
      pos = POS_HUNT;
      sum = '0;
      dist_q = '0;
      str_q = '0;
      temp_q = '0;
      errors = 0;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      result_t res;
      if (pos == POS_HUNT) begin
        if (b == marker) begin
          sum = b;
          pos = 4'd1;
        end
      end else if (pos >= FRAME_LEN - 1) begin
        res.distance = dist_q;
        res.signal_strength = str_q;
        res.raw_temperature = temp_q;
        res.temperature_eighths = {1'b0, temp_q} - TEMP_OFFSET;
        res.checksum_ok = (sum == b);
        expected_frames.push_back(res);
        pos = POS_HUNT;
        sum = '0;
      end else begin
        case (pos)
          POS_DIST_LO: dist_q[7:0] = b;
          POS_DIST_HI: dist_q[15:8] = b;
          POS_STR_LO: str_q[7:0] = b;
          POS_STR_HI: str_q[15:8] = b;
          POS_TEMP_LO: temp_q[7:0] = b;
          POS_TEMP_HI: temp_q[15:8] = b;
          default: ;
        endcase
        sum = sum + b;
        pos = pos + 4'd1;
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [TEMP_W-1:0] got, logic [TEMP_W-1:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
    endtask

    task check_frame(result_t got);
      result_t want;
      if (expected_frames.size() == 0) begin
        report_mismatch("result with no frame pending");
      end else begin
        want = expected_frames.pop_front();
        check_field("distance", got.distance, want.distance);
        check_field("signal_strength", got.signal_strength, want.signal_strength);
        check_field("raw_temperature", got.raw_temperature, want.raw_temperature);
        check_field("temperature_eighths", got.temperature_eighths,
                    want.temperature_eighths);
        check_field("checksum_ok", got.checksum_ok, want.checksum_ok);
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic [BYTE_W-1:0] rx_byte;
  logic out_valid;
  logic out_stall;
  logic [FIELD_W-1:0] distance;
  logic [FIELD_W-1:0] signal_strength;
  logic [FIELD_W-1:0] raw_temperature;
  logic signed [TEMP_W-1:0] temperature_eighths;
  logic checksum_ok;

  int src_idle_pct;
  int dst_idle_pct;
  frame_checker sb;

  lidar_data_frame_parser_core #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .distance(distance),
    .signal_strength(signal_strength),
    .raw_temperature(raw_temperature),
    .temperature_eighths(temperature_eighths),
    .checksum_ok(checksum_ok)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < dst_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_frame(result_t'{distance, signal_strength, raw_temperature,
                               temperature_eighths, checksum_ok});
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_marker(input logic [BYTE_W-1:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_HEADER_MARKER, 2'b00};
    pwdata <= {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.marker = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // bytes first..last-1 of a frame; the last byte carries the sum or a corrupted one
  task automatic send_frame(input logic [BYTE_W-1:0] mark, input logic [FIELD_W-1:0] dist_word,
                            input logic [FIELD_W-1:0] str, input logic [FIELD_W-1:0] temp,
                            input logic [BYTE_W-1:0] spare, input bit bad_sum,
                            input int first, input int last);
    logic [BYTE_W-1:0] fb [FRAME_LEN];
    logic [BYTE_W-1:0] sum;
    fb[0] = mark;
    fb[1] = spare;
    fb[2] = dist_word[7:0];
    fb[3] = dist_word[15:8];
    fb[4] = str[7:0];
    fb[5] = str[15:8];
    fb[6] = temp[7:0];
    fb[7] = temp[15:8];
    for (int i = 8; i < FRAME_LEN - 1; i++) fb[i] = spare ^ i[7:0];
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + fb[i];
    fb[FRAME_LEN-1] = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    for (int i = first; i < last; i++) send_byte(fb[i]);
  endtask

  function automatic logic [FIELD_W-1:0] rand_word(input logic [BYTE_W-1:0] mark);
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {mark, mark};
      3: return 16'h0800;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte(input logic [BYTE_W-1:0] mark);
    case ($urandom_range(9))
      0: return mark;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [BYTE_W-1:0] mark;
    int sent;
    int pick;
    int n;
    int waited;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    out_stall = 1'b0;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    sb = new();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset marker, extreme fields, good and bad sums, marker as data
    send_frame(MARKER_RESET, 16'h0000, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 0, FRAME_LEN);
    send_frame(MARKER_RESET, 16'hFFFF, {MARKER_RESET, MARKER_RESET}, 16'hFFFF,
               MARKER_RESET, 1'b1, 0, FRAME_LEN);
    // marker changes halfway through a frame
    send_frame(MARKER_RESET, 16'h1234, 16'h00FF, 16'h0800, 8'hA5, 1'b0, 0, 4);
    drain();
    write_marker(8'h00);
    send_frame(MARKER_RESET, 16'h1234, 16'h00FF, 16'h0800, 8'hA5, 1'b0, 4, FRAME_LEN);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin
          src_idle_pct = 27;
          dst_idle_pct = 88;
        end
        1: begin
          src_idle_pct = 88;
          dst_idle_pct = 27;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      case (ph)
        0, 5: mark = 8'h00;
        1, 7: mark = 8'hFF;
        4: mark = MARKER_RESET;
        default: mark = 8'($urandom_range(255));
      endcase
      write_marker(mark);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          send_frame(mark, rand_word(mark), rand_word(mark), rand_word(mark),
                     rand_byte(mark), $urandom_range(99) < 20, 0, FRAME_LEN);
          sent += FRAME_LEN;
        end else if (pick < 82) begin
          n = $urandom_range(1, FRAME_LEN - 1);
          send_frame(mark, rand_word(mark), rand_word(mark), rand_word(mark),
                     rand_byte(mark), 1'b0, 0, n);
          sent += n;
        end else if (pick < 84) begin
          drain();
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(rand_byte(mark));
        end
      end
      drain();
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_frames.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (6) @(negedge clk);
    if (sb.expected_frames.size() != 0) begin
      sb.report_mismatch($sformatf("%0d frames never came out", sb.expected_frames.size()));
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> sim.f
src/ldfp_pkg.sv
src/ldfp_frame.sv
src/lidar_data_frame_parser_core.sv
tb/tb.sv
